// File: rtl/fppa_pkg.sv
// shared types, codes and microcode table of the fit-policy partition allocator
package fppa_pkg;

   localparam int DEF_NUM_BLOCKS = 16;
   localparam int DEF_SIZE_BITS  = 16;

   localparam logic [4:0] DEF_BLOCK_COUNT = 5'd16;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_ALLOC = 1'b1;

   localparam logic CSR_FIT_POLICY  = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_INIT = 3'd1,
      ST_SCAN = 3'd2,
      ST_DONE = 3'd3,
      ST_LOAD = 3'd4
   } step_type;

   typedef enum logic [1:0] {
      H_NONE      = 2'd0,
      H_NO_REQ    = 2'd1,
      H_SCAN_MORE = 2'd2,
      H_OUT_BUSY  = 2'd3
   } hold_type;

   typedef enum logic [1:0] {
      B_NEVER      = 2'd0,
      B_ALWAYS     = 2'd1,
      B_IS_LOAD    = 2'd2,
      B_COUNT_ZERO = 2'd3
   } branch_type;

   typedef struct packed {
      logic       ready;
      logic       load_wr;
      logic       scan_init;
      logic       scan_step;
      logic       finish;
      hold_type   hold;
      branch_type branch;
      step_type   target;
   } ucode_type;

   typedef struct packed {
      logic ready;
      logic load_wr;
      logic scan_init;
      logic scan_step;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic req_load;
      logic count_zero;
      logic scan_end;
      logic out_free;
   } stat_type;

   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      w = '0;
      w.hold   = H_NONE;
      w.branch = B_ALWAYS;
      w.target = ST_IDLE;
      case (s)
         ST_IDLE: begin
            w.ready  = 1'b1;
            w.hold   = H_NO_REQ;
            w.branch = B_IS_LOAD;
            w.target = ST_LOAD;
         end
         ST_INIT: begin
            w.scan_init = 1'b1;
            w.branch    = B_COUNT_ZERO;
            w.target    = ST_DONE;
         end
         ST_SCAN: begin
            w.scan_step = 1'b1;
            w.hold      = H_SCAN_MORE;
            w.branch    = B_NEVER;
         end
         ST_DONE: begin
            w.finish = 1'b1;
            w.hold   = H_OUT_BUSY;
         end
         ST_LOAD: begin
            w.load_wr = 1'b1;
         end
         default: begin
            w.branch = B_ALWAYS;
         end
      endcase
      return w;
   endfunction

endpackage

// File: rtl/fppa_seq.sv
// microcode sequencer: step counter, control rom and jump logic
module fppa_seq (
   input  logic               clock,
   input  logic               reset,
   input  fppa_pkg::stat_type stat,
   output fppa_pkg::ctl_type  ctl
);
   import fppa_pkg::*;

   step_type  step_ff, step_in;
   ucode_type word;
   logic      hold_act;
   logic      branch_act;

   assign word = ucode_rom(step_ff);

   always_comb begin
      unique case (word.hold)
         H_NONE:      hold_act = 1'b0;
         H_NO_REQ:    hold_act = !stat.req_valid;
         H_SCAN_MORE: hold_act = !stat.scan_end;
         H_OUT_BUSY:  hold_act = !stat.out_free;
      endcase
      unique case (word.branch)
         B_NEVER:      branch_act = 1'b0;
         B_ALWAYS:     branch_act = 1'b1;
         B_IS_LOAD:    branch_act = stat.req_load;
         B_COUNT_ZERO: branch_act = stat.count_zero;
      endcase
      priority if (hold_act) begin
         step_in = step_ff;
      end else if (branch_act) begin
         step_in = word.target;
      end else begin
         step_in = step_type'(3'(step_ff) + 3'd1);
      end
   end

   always_comb begin
      ctl.ready     = word.ready;
      ctl.load_wr   = word.load_wr;
      ctl.scan_init = word.scan_init;
      ctl.scan_step = word.scan_step;
      ctl.finish    = word.finish && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// File: rtl/fppa_dpath.sv
// datapath: free size table, scan unit, request latch and result register
module fppa_dpath #(
   parameter int NUM_BLOCKS = fppa_pkg::DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = fppa_pkg::DEF_SIZE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  fppa_pkg::ctl_type  ctl,
   output fppa_pkg::stat_type stat,
   input  logic [1:0]         fit_policy,
   input  logic [4:0]         block_count,
   input  logic               req_valid,
   input  logic               req_action,
   input  logic [3:0]         req_block_index,
   input  logic [15:0]        req_size_value,
   input  logic               req_last_request,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_granted,
   output logic [3:0]         rsp_chosen_block,
   output logic [15:0]        rsp_remaining_size,
   output logic               rsp_last_of_batch
);
   import fppa_pkg::*;

   localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);

   logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] vld_ff, vld_in;

   logic [3:0]            idx_ff;
   logic [SIZE_BITS-1:0]  size_ff;
   logic                  last_ff;

   logic [CNT_BITS-1:0]   count_eff;
   logic [CNT_BITS-1:0]   j_ff, j_in;
   logic [CNT_BITS-1:0]   j_next;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   pick_ff, pick_in;
   logic [SIZE_BITS-1:0]  pick_size_ff, pick_size_in;

   logic [IDX_BITS-1:0]   rd_addr;
   logic [SIZE_BITS-1:0]  rd_data_ff;
   logic                  rd_vld_ff;
   logic [SIZE_BITS-1:0]  scan_val;
   logic                  fits, take, is_best, is_worst;

   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [SIZE_BITS-1:0]  wr_data;
   logic [SIZE_BITS-1:0]  remaining;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  granted_ff;
   logic [3:0]            chosen_ff;
   logic [15:0]           rem_ff;
   logic                  last_out_ff;

   // blocks in use, clamped to the table depth
   always_comb begin
      if (32'(block_count) > NUM_BLOCKS) begin
         count_eff = CNT_BITS'(NUM_BLOCKS);
      end else begin
         count_eff = CNT_BITS'(block_count);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ready && req_valid) begin
         idx_ff  <= req_block_index;
         size_ff <= SIZE_BITS'(req_size_value);
         last_ff <= req_last_request;
      end
   end

   // scan read port
   assign j_next  = CNT_BITS'(j_ff + CNT_BITS'(1));
   assign rd_addr = ctl.scan_init ? '0 : IDX_BITS'(j_next);

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

   assign scan_val = rd_vld_ff ? rd_data_ff : '0;
   assign is_best  = (fit_policy == POL_BEST);
   assign is_worst = (fit_policy == POL_WORST);
   assign fits     = (scan_val >= size_ff);
   assign take     = fits && (!found_ff
                     || (is_best && (scan_val < pick_size_ff))
                     || (is_worst && (scan_val > pick_size_ff)));

   always_comb begin
      j_in         = j_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      pick_size_in = pick_size_ff;
      if (ctl.scan_init) begin
         j_in     = '0;
         found_in = 1'b0;
      end else if (ctl.scan_step) begin
         j_in = j_next;
         if (take) begin
            found_in     = 1'b1;
            pick_in      = j_ff[IDX_BITS-1:0];
            pick_size_in = scan_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff     <= '0;
         found_ff <= 1'b0;
      end else begin
         j_ff     <= j_in;
         found_ff <= found_in;
      end
      pick_ff      <= pick_in;
      pick_size_ff <= pick_size_in;
   end

   // table write port: loads and grant write-back
   assign remaining = pick_size_ff - size_ff;
   assign wr_en     = (ctl.load_wr && (32'(idx_ff) < NUM_BLOCKS)) || (ctl.finish && found_ff);
   assign wr_addr   = ctl.load_wr ? IDX_BITS'(idx_ff) : pick_ff;
   assign wr_data   = ctl.load_wr ? size_ff : remaining;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctl.finish) begin
         granted_ff  <= found_ff;
         chosen_ff   <= found_ff ? 4'(pick_ff) : 4'd0;
         rem_ff      <= found_ff ? 16'(remaining) : 16'd0;
         last_out_ff <= last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = granted_ff;
   assign rsp_chosen_block   = chosen_ff;
   assign rsp_remaining_size = rem_ff;
   assign rsp_last_of_batch  = last_out_ff;

   always_comb begin
      stat.req_valid  = req_valid;
      stat.req_load   = (req_action == ACT_LOAD);
      stat.count_zero = (count_eff == '0);
      stat.scan_end   = (j_next == count_eff) || (fits && !found_ff && !is_best && !is_worst);
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// File: rtl/fit_policy_partition_allocator_unit.sv
// top level of the fit-policy partition allocator
//
// requests come in on req_* (valid/stall), results leave on rsp_* (valid/stall).
// a load request writes one block's free size and returns nothing; it is
// taken in the idle step and written to the table in the load step.
// an allocate request scans the blocks in use from index zero, one table read
// per cycle, picks a block by the first, best or worst fit policy and writes
// the reduced size back. the result is registered in the done step once the
// scan ends (early when first fit hits); the next request is taken only after
// the block returns to idle. the length of the scan is set by the single read
// port of the size table.
// a request with no fitting block returns not granted and leaves the table.
// the result sits in an output register; while the receiver stalls it holds,
// and the block still takes a new request and scans. a finished scan waits
// for the register to free up before writing back.
// reset clears the table at once through per-block valid bits, sets first fit
// and 16 blocks in use; the block takes requests in the next cycle. csr writes
// are registered, to be made only while the block is idle; this is not enforced.
module fit_policy_partition_allocator_unit #(
   parameter int NUM_BLOCKS = fppa_pkg::DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = fppa_pkg::DEF_SIZE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [3:0]  req_block_index,
   input  logic [15:0] req_size_value,
   input  logic        req_last_request,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_granted,
   output logic [3:0]  rsp_chosen_block,
   output logic [15:0] rsp_remaining_size,
   output logic        rsp_last_of_batch,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);
   import fppa_pkg::*;

   logic [1:0] fit_policy_ff;
   logic [4:0] block_count_ff;
   ctl_type    ctl;
   stat_type   stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff  <= POL_FIRST;
         block_count_ff <= DEF_BLOCK_COUNT;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FIT_POLICY:  fit_policy_ff  <= csr_wdata[1:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata;
         endcase
      end
   end

   fppa_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   fppa_dpath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .stat               (stat),
      .fit_policy         (fit_policy_ff),
      .block_count        (block_count_ff),
      .req_valid          (req_valid),
      .req_action         (req_action),
      .req_block_index    (req_block_index),
      .req_size_value     (req_size_value),
      .req_last_request   (req_last_request),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_granted        (rsp_granted),
      .rsp_chosen_block   (rsp_chosen_block),
      .rsp_remaining_size (rsp_remaining_size),
      .rsp_last_of_batch  (rsp_last_of_batch)
   );

   assign req_stall = !ctl.ready;

   a_finish_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> rsp_valid)
      else $error("finished scan did not present a result");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_action == ACT_LOAD) && !rsp_valid
       && !ctl.finish) |=> !rsp_valid)
      else $error("load request produced a result");

   a_not_granted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |-> ((rsp_chosen_block == 4'd0)
                                       && (rsp_remaining_size == 16'd0)))
      else $error("not granted result carries nonzero fields");

   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      (ctl.scan_step || ctl.scan_init || ctl.load_wr) |-> req_stall)
      else $error("request taken while a request is in progress");

endmodule
